/* rtl/fp32_add_subtract_macros.svh */
// assertion macros for the single-precision adder
`ifndef FP32_ADD_SUBTRACT_MACROS_SVH
`define FP32_ADD_SUBTRACT_MACROS_SVH

// implication checked on every clock edge outside reset
`define FAS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define FAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fas_pkg.sv */
// shared types, constants and helpers for the single-precision adder
`timescale 1ns / 1ps

package fas_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned ManW  = 23;
    localparam logic [ExpW-1:0] ExpMax = 8'hFF;
    localparam logic [4:0] ShiftCap = 5'h1F;
    localparam logic [2:0] RoundTie = 3'b110;
    localparam logic [1:0] RoundHalf = 2'b10;
    localparam logic [1:0] RoundOver = 2'b11;
    localparam logic [WordW-1:0] DefaultNan = 32'hFFC0_0000;

    typedef enum logic
    {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } op_t;

    // front stage result handed to the back stage
    typedef struct packed
    {
        logic [25:0]     myd;
        logic [ExpW-1:0] eyd;
        logic            stck;
        logic            same;
        logic            ss;
        logic            s1;
        logic            s2;
        logic            special;
        logic [WordW-1:0] special_word;
    } fas_mid_t;

    // leading-zero count over 26 bits, 26 when all zero
    function automatic logic [4:0] lz26(input logic [25:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd26;
        found = 1'b0;
        for (int i = 25; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n = 5'(25 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

/* rtl/fas_align.sv */
// operand unpack, alignment, add/subtract and special-operand resolution
`timescale 1ns / 1ps

module fas_align
(
    input  logic                       op,
    input  logic [fas_pkg::WordW-1:0]  operand_a,
    input  logic [fas_pkg::WordW-1:0]  operand_b,
    output fas_pkg::fas_mid_t          mid
);
    import fas_pkg::*;

    logic        s1, s2;
    logic [7:0]  e1, e2, e1a, e2a, tde, es, esi;
    logic [22:0] m1, m2;
    logic [23:0] m1a, m2a, ms, mi;
    logic [8:0]  te;
    logic        b_big, sel, tstck, carry, i1, i2, nz1, nz2;
    logic [4:0]  de;
    logic [54:0] mia;
    logic [26:0] small_v, mye;
    logic        rs;
    logic [22:0] rm;

    always_comb
    begin
        s1 = operand_a[31];
        e1 = operand_a[30:23];
        m1 = operand_a[22:0];
        s2 = operand_b[31] ^ (op == OP_SUB);
        e2 = operand_b[30:23];
        m2 = operand_b[22:0];
        m1a = {(e1 != 8'd0), m1};
        m2a = {(e2 != 8'd0), m2};
        e1a = (e1 != 8'd0) ? e1 : 8'd1;
        e2a = (e2 != 8'd0) ? e2 : 8'd1;
        te = {1'b0, e1a} + {1'b0, ~e2a};
        b_big = !te[8];
        tde = b_big ? ~te[7:0] : (te[7:0] + 8'd1);
        de = (tde[7:5] != 3'd0) ? ShiftCap : tde[4:0];
        sel = (de != 5'd0) ? b_big : !(m1a > m2a);
        ms = sel ? m2a : m1a;
        mi = sel ? m1a : m2a;
        es = sel ? e2a : e1a;
        mid.ss = sel ? s2 : s1;
        mia = {mi, 31'd0} >> de;
        tstck = (mia[28:0] != 29'd0);
        small_v = {1'b0, mia[54:29]};
        mid.same = (s1 == s2);
        mye = mid.same ? ({1'b0, ms, 2'b00} + small_v) : ({1'b0, ms, 2'b00} - small_v);
        esi = es + 8'd1;
        carry = mye[26];
        mid.eyd = carry ? esi : es;
        mid.myd = carry ? ((esi == ExpMax) ? 26'h200_0000 : mye[26:1]) : mye[25:0];
        mid.stck = carry ? ((esi != ExpMax) && (tstck || mye[0])) : tstck;
        mid.s1 = s1;
        mid.s2 = s2;

        i1 = (e1 == ExpMax);
        i2 = (e2 == ExpMax);
        nz1 = (m1 != 23'd0);
        nz2 = (m2 != 23'd0);
        rs = 1'b0;
        rm = 23'd0;
        priority if (i1 && !i2)
        begin
            rs = s1; rm = {nz1, m1[21:0]};
        end
        else if (!i1 && i2)
        begin
            rs = s2; rm = {nz2, m2[21:0]};
        end
        else if (i1 && i2 && nz2)
        begin
            rs = s2; rm = {1'b1, m2[21:0]};
        end
        else if (i1 && i2 && nz1)
        begin
            rs = s1; rm = {1'b1, m1[21:0]};
        end
        else if (i1 && i2 && mid.same)
        begin
            rs = s1; rm = 23'd0;
        end
        else
        begin
            rs = DefaultNan[31]; rm = DefaultNan[22:0];
        end
        mid.special = i1 || i2;
        mid.special_word = {rs, ExpMax, rm};
    end

endmodule

/* rtl/fas_round.sv */
// normalization, rounding and result packing
`timescale 1ns / 1ps

module fas_round
(
    input  fas_pkg::fas_mid_t          mid,
    output logic [fas_pkg::WordW-1:0]  sum_word
);
    import fas_pkg::*;

    logic [4:0]  se;
    logic [8:0]  eyf;
    logic        normal, up;
    logic [25:0] myf;
    logic [7:0]  eyr, ey, edm1;
    logic [24:0] trunc, myr;
    logic [22:0] my;
    logic        sy;

    always_comb
    begin
        se = lz26(mid.myd);
        eyf = {1'b0, mid.eyd} - {4'd0, se};
        normal = !eyf[8] && (eyf[7:0] != 8'd0);
        edm1 = mid.eyd - 8'd1;
        myf = normal ? (mid.myd << se) : (mid.myd << edm1[4:0]);
        eyr = normal ? eyf[7:0] : 8'd0;
        trunc = {1'b0, myf[25:2]};
        up = ((myf[2:0] == RoundTie) && !mid.stck)
            || ((myf[1:0] == RoundHalf) && mid.same && mid.stck)
            || (myf[1:0] == RoundOver);
        myr = up ? (trunc + 25'd1) : trunc;
        priority if (myr[24])
        begin
            ey = eyr + 8'd1; my = 23'd0;
        end
        else if (myr[23:0] != 24'd0)
        begin
            ey = eyr; my = myr[22:0];
        end
        else
        begin
            ey = 8'd0; my = 23'd0;
        end
        sy = ((ey == 8'd0) && (my == 23'd0)) ? (mid.s1 & mid.s2) : mid.ss;
        sum_word = mid.special ? mid.special_word : {sy, ey, my};
    end

endmodule

/* rtl/fp32_add_subtract.sv */
// single-precision adder and subtracter, top level
//
// input channel: in_valid/in_stall carry op, operand_a and operand_b;
// a transaction moves when valid is high and stall is low.
// output channel: out_valid/out_stall carry sum_bits.
// op low adds, op high subtracts operand_b from operand_a.
// stages: an input register, then alignment and add logic into a middle
// register, then normalize and round into the result register (three
// register stages); throughput is one transaction per cycle when not stalled.
// a stall on the output freezes the result stage and each full stage
// directly behind it, while a stage behind a bubble still advances; the
// input stall rises only when the pipeline is full and output is stalled.
// reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "fp32_add_subtract_macros.svh"

module fp32_add_subtract
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sum_bits
);
    import fas_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    logic        op_reg;
    logic [31:0] a_reg, b_reg, res_reg;
    fas_mid_t    mid_next, mid_reg;
    logic [31:0] sum_next;
    logic        adv3, adv2, adv1;

    assign adv3 = !v3_reg || !out_stall;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_stall = !adv1;
    assign out_valid = v3_reg;
    assign sum_bits = res_reg;

    fas_align u_align
    (
        .op        (op_reg),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .mid       (mid_next)
    );

    fas_round u_round
    (
        .mid      (mid_reg),
        .sum_word (sum_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            op_reg <= op;
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (adv2 && v1_reg)
        begin
            mid_reg <= mid_next;
        end
        if (adv3 && v2_reg)
        begin
            res_reg <= sum_next;
        end
    end

    `FAS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sum_bits), "stalled result changed")
    `FAS_ASSERT_IMP(a_stall_full, in_stall, v1_reg && v2_reg && v3_reg && out_stall, "input stalled while pipeline has room")
    `FAS_ASSERT_NEXT(a_flow, v2_reg && !out_stall, out_valid, "middle stage lost a transaction")

endmodule
